// File: sv/crtb_pkg.sv
// Shared types, constants and helper functions of the reload timer bank.
package crtb_pkg;

  localparam int NUM_TIMERS = 4;

  localparam int CNT_W   = 16;
  localparam int MASK_W  = 16;
  localparam int CTL_W   = 8;
  localparam int PS_W    = 10;
  localparam int SH_W    = 4;
  localparam int TYPE_W  = 2;
  localparam int IDX_W   = 2;
  localparam int IRQ_W   = 4;
  localparam int FIFO_W  = 2;
  localparam int FIFO_TIMERS = 2;

  localparam logic [CTL_W-1:0] CTL_KEEP = 8'hC7;
  localparam int CTL_ENABLE_BIT  = 7;
  localparam int CTL_IRQ_BIT     = 6;
  localparam int CTL_COUNTUP_BIT = 2;

  typedef enum logic [TYPE_W-1:0] {
    REQ_TICK    = 2'd0,
    REQ_RELOAD  = 2'd1,
    REQ_CONTROL = 2'd2,
    REQ_READ    = 2'd3
  } req_type_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [IDX_W-1:0]  timer_index;
    logic [MASK_W-1:0] write_mask;
    logic [MASK_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  read_data;
    logic [IRQ_W-1:0]  irq_pulses;
    logic [FIFO_W-1:0] fifo_events;
  } rsp_t;

  // Terminal count of the prescaler for a given shift.
  function automatic logic [PS_W-1:0] prescale_limit(input logic [SH_W-1:0] shift);
    logic [PS_W-1:0] lim;
    if (shift >= SH_W'(PS_W)) begin
      lim = '1;
    end else begin
      lim = (PS_W'(1) << shift) - PS_W'(1);
    end
    return lim;
  endfunction

  // Shift for a prescale select; zero when cascaded.
  function automatic logic [SH_W-1:0] prescale_shift_of(input logic [1:0] sel,
                                                        input logic cascaded);
    logic [SH_W-1:0] sh;
    unique case (sel)
      2'd0: sh = SH_W'(0);
      2'd1: sh = SH_W'(6);
      2'd2: sh = SH_W'(8);
      2'd3: sh = SH_W'(10);
      default: sh = SH_W'(0);
    endcase
    if (cascaded) begin
      sh = SH_W'(0);
    end
    return sh;
  endfunction

endpackage

// File: sv/crtb_req_if.sv
// Request channel interface of the reload timer bank.
interface crtb_req_if;
  logic                         valid;
  logic                         ready;
  logic [crtb_pkg::TYPE_W-1:0]  req_type;
  logic [crtb_pkg::IDX_W-1:0]   timer_index;
  logic [crtb_pkg::MASK_W-1:0]  write_mask;
  logic [crtb_pkg::MASK_W-1:0]  write_data;

  modport source(output valid, req_type, timer_index, write_mask, write_data, input ready);
  modport sink(input valid, req_type, timer_index, write_mask, write_data, output ready);
endinterface

// File: sv/crtb_rsp_if.sv
// Result channel interface of the reload timer bank.
interface crtb_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [crtb_pkg::CNT_W-1:0]   read_data;
  logic [crtb_pkg::IRQ_W-1:0]   irq_pulses;
  logic [crtb_pkg::FIFO_W-1:0]  fifo_events;

  modport source(output valid, read_data, irq_pulses, fifo_events, input ready);
  modport sink(input valid, read_data, irq_pulses, fifo_events, output ready);
endinterface

// File: sv/crtb_timer_core.sv
// Timer state, prescalers, cascade chain and register write logic.
module crtb_timer_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           legacy_mode,
  input  logic           fire,
  input  crtb_pkg::req_t beat,
  output crtb_pkg::rsp_t result
);

  localparam int N = crtb_pkg::NUM_TIMERS;
  localparam int IRQ_EXT_W = (N > crtb_pkg::IRQ_W) ? N : crtb_pkg::IRQ_W;

  logic [crtb_pkg::CNT_W-1:0] cnt      [N];
  logic [crtb_pkg::CNT_W-1:0] rel      [N];
  logic [crtb_pkg::CTL_W-1:0] ctl      [N];
  logic [crtb_pkg::PS_W-1:0]  ps_cnt   [N];
  logic [crtb_pkg::SH_W-1:0]  ps_sh    [N];

  logic [crtb_pkg::CNT_W-1:0] cnt_next    [N];
  logic [crtb_pkg::CNT_W-1:0] rel_next    [N];
  logic [crtb_pkg::CTL_W-1:0] ctl_next    [N];
  logic [crtb_pkg::PS_W-1:0]  ps_cnt_next [N];
  logic [crtb_pkg::SH_W-1:0]  ps_sh_next  [N];

  logic [N-1:0]                  irq_vec;
  logic [crtb_pkg::FIFO_W-1:0]   fifo_vec;
  logic [crtb_pkg::CNT_W-1:0]    rd;
  logic [IRQ_EXT_W-1:0]          irq_ext;

  always_comb begin
    logic                       carry;
    logic                       own;
    logic                       inc;
    logic                       en;
    logic                       cu;
    logic                       sel;
    logic [crtb_pkg::CTL_W-1:0] m;
    logic [crtb_pkg::CTL_W-1:0] nw;
    logic [crtb_pkg::SH_W-1:0]  sh;
    for (int i = 0; i < N; i++) begin
      cnt_next[i]    = cnt[i];
      rel_next[i]    = rel[i];
      ctl_next[i]    = ctl[i];
      ps_cnt_next[i] = ps_cnt[i];
      ps_sh_next[i]  = ps_sh[i];
    end
    irq_vec  = '0;
    fifo_vec = '0;
    rd       = '0;
    carry    = 1'b0;
    own      = 1'b0;
    inc      = 1'b0;
    en       = 1'b0;
    cu       = 1'b0;
    sel      = 1'b0;
    m        = '0;
    nw       = '0;
    sh       = '0;
    unique case (crtb_pkg::req_type_t'(beat.req_type))
      crtb_pkg::REQ_TICK: begin
        // timers in order; carry moves a wrap into the next count-up timer
        for (int i = 0; i < N; i++) begin
          en  = ctl[i][crtb_pkg::CTL_ENABLE_BIT];
          cu  = (i != 0) && ctl[i][crtb_pkg::CTL_COUNTUP_BIT];
          own = 1'b0;
          if (en && !cu) begin
            if (ps_cnt[i] < crtb_pkg::prescale_limit(ps_sh[i])) begin
              ps_cnt_next[i] = ps_cnt[i] + crtb_pkg::PS_W'(1);
            end else begin
              ps_cnt_next[i] = '0;
              own = 1'b1;
            end
          end
          inc   = own || (carry && cu);
          carry = 1'b0;
          if (inc) begin
            if (cnt[i] == '1) begin
              if (en) begin
                cnt_next[i] = rel[i];
                irq_vec[i]  = ctl[i][crtb_pkg::CTL_IRQ_BIT];
                if (legacy_mode && (i < crtb_pkg::FIFO_TIMERS)) begin
                  fifo_vec[i] = 1'b1;
                end
                carry = 1'b1;
              end else begin
                cnt_next[i] = '0;
              end
            end else begin
              cnt_next[i] = cnt[i] + crtb_pkg::CNT_W'(1);
            end
          end
        end
      end
      crtb_pkg::REQ_RELOAD: begin
        for (int i = 0; i < N; i++) begin
          sel = (32'(beat.timer_index) == i);
          if (sel) begin
            rel_next[i] = (rel[i] & ~beat.write_mask) | (beat.write_data & beat.write_mask);
          end
        end
      end
      crtb_pkg::REQ_CONTROL: begin
        for (int i = 0; i < N; i++) begin
          sel = (32'(beat.timer_index) == i);
          if (sel) begin
            m  = beat.write_mask[crtb_pkg::CTL_W-1:0] & crtb_pkg::CTL_KEEP;
            nw = (ctl[i] & ~m) | (beat.write_data[crtb_pkg::CTL_W-1:0] & m);
            sh = crtb_pkg::prescale_shift_of(nw[1:0],
                   (i != 0) && nw[crtb_pkg::CTL_COUNTUP_BIT]);
            ctl_next[i] = nw;
            if (sh != ps_sh[i]) begin
              ps_sh_next[i]  = sh;
              ps_cnt_next[i] = '0;
            end
            if (!ctl[i][crtb_pkg::CTL_ENABLE_BIT] && nw[crtb_pkg::CTL_ENABLE_BIT]) begin
              cnt_next[i]    = rel[i];
              ps_cnt_next[i] = '0;
            end
          end
        end
      end
      crtb_pkg::REQ_READ: begin
        for (int i = 0; i < N; i++) begin
          sel = (32'(beat.timer_index) == i);
          if (sel) begin
            rd = cnt[i];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign irq_ext            = IRQ_EXT_W'(irq_vec);
  assign result.read_data   = rd;
  assign result.irq_pulses  = irq_ext[crtb_pkg::IRQ_W-1:0];
  assign result.fifo_events = fifo_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        cnt[i]    <= '0;
        rel[i]    <= '0;
        ctl[i]    <= '0;
        ps_cnt[i] <= '0;
        ps_sh[i]  <= '0;
      end
    end else if (fire) begin
      for (int i = 0; i < N; i++) begin
        cnt[i]    <= cnt_next[i];
        rel[i]    <= rel_next[i];
        ctl[i]    <= ctl_next[i];
        ps_cnt[i] <= ps_cnt_next[i];
        ps_sh[i]  <= ps_sh_next[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_fifo_needs_legacy: assert property (@(posedge clk) disable iff (rst)
    (fire && (result.fifo_events != '0)) |-> legacy_mode)
    else $error("fifo event outside legacy mode");

  a_ps_in_range: assert property (@(posedge clk) disable iff (rst)
    ps_cnt[0] <= crtb_pkg::prescale_limit(ps_sh[0]))
    else $error("prescaler of timer 0 past its terminal count");

  a_ctl_unused_zero: assert property (@(posedge clk) disable iff (rst)
    ctl[0][5:3] == 3'b000)
    else $error("unused control bits set");
`endif

endmodule

// File: sv/cascadable_reload_timer_bank.sv
// Four-channel cascadable prescaled reload timer bank, top level.
//
// Requests arrive on req (valid/ready): tick, reload write, control write or
// counter read; all but ticks address timer_index, writes go under write_mask.
// Every request beat yields exactly one result beat on rsp: read_data holds
// the counter for a read and is zero otherwise; irq_pulses and fifo_events
// flag overflows during a tick.
// legacy_mode is written through cfg_we/cfg_wdata; the user must write it
// only while the bank is idle, which the bank itself does not enforce.
// Throughput: one request per cycle while rsp is not stalled, from the request
// register through a single pass of timer logic into the result register.
// A stalled rsp holds its beat; one more request can be taken into the
// request register, after which req.ready drops until rsp drains.
// Reset (rst, synchronous) clears all counters, reload and control
// registers, prescalers, legacy_mode and the valid bits of both pipeline stages.
module cascadable_reload_timer_bank (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_wdata,
  crtb_req_if.sink   req,
  crtb_rsp_if.source rsp
);

  logic           legacy_mode;
  logic           in_valid;
  crtb_pkg::req_t in_beat;
  logic           out_valid;
  crtb_pkg::rsp_t out_beat;
  crtb_pkg::rsp_t core_rsp;
  logic           advance;

  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      legacy_mode <= 1'b0;
    end else if (cfg_we) begin
      legacy_mode <= cfg_wdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_beat.req_type    <= req.req_type;
      in_beat.timer_index <= req.timer_index;
      in_beat.write_mask  <= req.write_mask;
      in_beat.write_data  <= req.write_data;
    end
  end

  crtb_timer_core u_core (
    .clk         (clk),
    .rst         (rst),
    .legacy_mode (legacy_mode),
    .fire        (advance),
    .beat        (in_beat),
    .result      (core_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_beat <= core_rsp;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.read_data   = out_beat.read_data;
  assign rsp.irq_pulses  = out_beat.irq_pulses;
  assign rsp.fifo_events = out_beat.fifo_events;

`ifndef SYNTHESIS
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_beat)))
    else $error("request register lost a stalled beat");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed beat not presented on rsp");
`endif

endmodule
